// ----- src/spq_pkg.sv -----
`default_nettype none
package spq_pkg;

    // Queue depth and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Operation codes
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One held entry
    typedef struct packed {
        logic [6:0] entry_time;
        logic [7:0] entry_info;
    } entry_t;

    // Command word
    typedef struct packed {
        logic       kind;
        logic [6:0] entry_time;
        logic [7:0] entry_info;
    } cmd_word_t;

    // Result word
    typedef struct packed {
        logic [1:0] status;
        logic [6:0] out_time;
        logic [7:0] out_info;
        logic [4:0] count;
    } result_word_t;

    // Per-cell control from the top level
    typedef struct packed {
        logic insert;      // enqueue into a non-full queue
        logic shift;       // dequeue from a non-empty queue
        logic valid;       // this cell holds an entry
        logic left_valid;  // left neighbor holds an entry (1 for head)
        logic left_gt;     // left neighbor time is above the new time
    } cell_ctl_t;

endpackage
`default_nettype wire

// ----- src/spq_cell.sv -----
`default_nettype none
module spq_cell (
    input  wire logic               clk,
    input  wire spq_pkg::cell_ctl_t ctl,
    input  wire spq_pkg::entry_t    new_entry,
    input  wire spq_pkg::entry_t    left_entry,
    input  wire spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t         entry,
    output logic                    gt
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // Held entry sorts after the new one
    assign gt = ctl.valid && (entry_reg.entry_time > new_entry.entry_time);

    // Insert: shift right past larger times, take the new word at the boundary; dequeue: take the right neighbor
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert)
        begin
            if (ctl.left_gt)
                entry_next = left_entry;
            else if (gt || (!ctl.valid && ctl.left_valid))
                entry_next = new_entry;
        end
        else if (ctl.shift)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

// ----- src/sorted_priority_queue.sv -----
`default_nettype none
// Sorted priority queue as a row of insertion cells.
// The result word is registered and appears in the cycle after start is taken.
// Throughput: one command per cycle; every cell compares and shifts in parallel.
// busy stays low, and results are strobed by done for one cycle.
// Reset clears the entry count and done; cell contents are not reset.
module sorted_priority_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire spq_pkg::cmd_word_t    cmd,
    output logic                       busy,
    output logic                       done,
    output spq_pkg::result_word_t      result
);

    localparam int N = spq_pkg::CAPACITY;

    logic [spq_pkg::CNT_W-1:0] count_reg;
    logic [spq_pkg::CNT_W-1:0] count_next;
    logic                      done_reg;
    spq_pkg::result_word_t     result_reg;
    spq_pkg::result_word_t     result_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic                      do_insert;
    logic                      do_shift;
    spq_pkg::entry_t           new_entry;
    spq_pkg::entry_t           cell_entry [N];
    logic [N-1:0]              cell_gt;
    logic [N-1:0]              cell_valid;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign full      = (count_reg == spq_pkg::CNT_W'(N));
    assign empty     = (count_reg == '0);
    assign do_insert = accept && (cmd.kind == spq_pkg::KIND_ENQ) && !full;
    assign do_shift  = accept && (cmd.kind == spq_pkg::KIND_DEQ) && !empty;

    assign new_entry.entry_time = cmd.entry_time;
    assign new_entry.entry_info = cmd.entry_info;

    // Cell row
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        spq_pkg::cell_ctl_t ctl;
        spq_pkg::entry_t    left_e;
        spq_pkg::entry_t    right_e;

        assign cell_valid[i] = (spq_pkg::CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign ctl.left_valid = 1'b1;
            assign ctl.left_gt    = 1'b0;
            assign left_e         = new_entry;
        end
        else
        begin : g_body
            assign ctl.left_valid = cell_valid[i-1];
            assign ctl.left_gt    = cell_gt[i-1];
            assign left_e         = cell_entry[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        assign ctl.insert = do_insert;
        assign ctl.shift  = do_shift;
        assign ctl.valid  = cell_valid[i];

        spq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    // Count update and result word
    always_comb
    begin
        count_next  = count_reg;
        result_next = '0;
        if (do_insert)
            count_next = count_reg + 1'b1;
        else if (do_shift)
            count_next = count_reg - 1'b1;

        if (cmd.kind == spq_pkg::KIND_ENQ)
        begin
            result_next.status = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
        end
        else if (empty)
        begin
            result_next.status = spq_pkg::ST_EMPTY;
        end
        else
        begin
            result_next.status   = spq_pkg::ST_OK;
            result_next.out_time = cell_entry[0].entry_time;
            result_next.out_info = cell_entry[0].entry_info;
        end
        result_next.count = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // Every accepted word yields a result next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("missing result strobe");

    // Count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::CNT_W'(N))
        else $error("count exceeds capacity");

    // Successful dequeue drops the count by one
    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_shift |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("dequeue count mismatch");

    // A refused enqueue reports a full queue
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == spq_pkg::ST_FULL) |-> (count_reg == spq_pkg::CNT_W'(N)))
        else $error("full status with room left");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_sorted_priority_queue.sv -----
module tb_sorted_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         start;
    cmd_word_t    cmd;
    logic         busy;
    logic         done;
    result_word_t result;

    // Golden copy of the queue contents, head at index 0
    entry_t       sorted_entries[$];
    // Result words predicted but not yet seen on the result port
    result_word_t pending_results[$];

    int error_count   = 0;
    int checked_count = 0;
    int enq_count     = 0;
    int deq_count     = 0;
    int full_count    = 0;
    int empty_count   = 0;

    sorted_priority_queue DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // One line per problem, counted
    task automatic report_error(input string msg);
        error_count++;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Apply one accepted command word to the golden queue and queue up its result word
    task automatic update_queue_model(input cmd_word_t w);
        result_word_t r;
        entry_t       e;
        int           pos;
        r = '0;
        if (w.kind == KIND_ENQ)
        begin
            enq_count++;
            if (sorted_entries.size() >= CAPACITY)
            begin
                r.status = ST_FULL;
                full_count++;
            end
            else
            begin
                // insert behind every entry with an equal or smaller time
                e.entry_time = w.entry_time;
                e.entry_info = w.entry_info;
                pos = sorted_entries.size();
                while (pos > 0 && sorted_entries[pos - 1].entry_time > w.entry_time)
                    pos--;
                sorted_entries.insert(pos, e);
                r.status = ST_OK;
            end
        end
        else
        begin
            deq_count++;
            if (sorted_entries.size() == 0)
            begin
                r.status = ST_EMPTY;
                empty_count++;
            end
            else
            begin
                e = sorted_entries.pop_front();
                r.status   = ST_OK;
                r.out_time = e.entry_time;
                r.out_info = e.entry_info;
            end
        end
        r.count = 5'(sorted_entries.size());
        pending_results.push_back(r);
    endtask

    // Present one command word and hold it until it is taken
    task automatic send_word(input cmd_word_t w);
        start <= 1'b1;
        cmd   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        update_queue_model(w);
    endtask

    // Drop start for an idle gap; the command bus carries junk meanwhile
    task automatic idle_for(input int n);
        cmd_word_t junk;
        if (n > 0)
        begin
            junk.kind       = 1'($urandom);
            junk.entry_time = 7'($urandom);
            junk.entry_info = 8'($urandom);
            start <= 1'b0;
            cmd   <= junk;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic int pick_gap(input int idle_pct);
        int g;
        g = 0;
        while (g < 40 && $urandom_range(99) < idle_pct)
            g++;
        return g;
    endfunction

    function automatic cmd_word_t make_word(input logic kind, input int t, input int info);
        cmd_word_t w;
        w.kind       = kind;
        w.entry_time = 7'(t);
        w.entry_info = 8'(info);
        return w;
    endfunction

    // Random word; narrow time ranges pile up ties, full range goes past 100
    function automatic cmd_word_t random_word(input int enq_pct);
        cmd_word_t w;
        int        sel;
        sel = $urandom_range(99);
        w.kind = ($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
        if (sel < 60)
            w.entry_time = 7'($urandom_range(100, 1));
        else if (sel < 85)
            w.entry_time = 7'($urandom_range(4, 1));
        else
            w.entry_time = 7'($urandom);
        w.entry_info = 8'($urandom);
        return w;
    endfunction

    // Check every strobed result word against the oldest prediction
    always @(posedge clk)
    begin : result_check
        result_word_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_error($sformatf("unexpected result word status=%0d time=%0d info=%0d count=%0d",
                                       result.status, result.out_time, result.out_info, result.count));
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                if (result.status !== want.status)
                    report_error($sformatf("status got %0d want %0d", result.status, want.status));
                if (result.out_time !== want.out_time)
                    report_error($sformatf("out_time got %0d want %0d",
                                           result.out_time, want.out_time));
                if (result.out_info !== want.out_info)
                    report_error($sformatf("out_info got %0d want %0d",
                                           result.out_info, want.out_info));
                if (result.count !== want.count)
                    report_error($sformatf("count got %0d want %0d", result.count, want.count));
            end
        end
    end

    // Dequeue from the empty queue, ignored fields all ones
    task automatic test_empty_dequeue();
        send_word(make_word(KIND_DEQ, 127, 255));
    endtask

    // Time and info extremes, including times outside 1..100
    task automatic test_time_extremes();
        send_word(make_word(KIND_ENQ, 127, 255));
        send_word(make_word(KIND_ENQ, 0, 0));
        send_word(make_word(KIND_ENQ, 100, 8'ha5));
        send_word(make_word(KIND_ENQ, 1, 8'h5a));
        send_word(make_word(KIND_DEQ, 0, 0));
        send_word(make_word(KIND_DEQ, 127, 255));
    endtask

    // Equal times must leave in arrival order
    task automatic test_tie_order();
        send_word(make_word(KIND_ENQ, 50, 1));
        send_word(make_word(KIND_ENQ, 50, 2));
        send_word(make_word(KIND_ENQ, 20, 3));
        send_word(make_word(KIND_ENQ, 50, 3));
        send_word(make_word(KIND_DEQ, 0, 0));
    endtask

    // Fill to capacity, refuse one more, then pull the head
    task automatic test_full_refusal();
        while (sorted_entries.size() < CAPACITY)
            send_word(make_word(KIND_ENQ, $urandom_range(100, 1), $urandom));
        send_word(make_word(KIND_ENQ, 0, 8'h3c));
        send_word(make_word(KIND_DEQ, 0, 0));
    endtask

    // Bursts biased toward filling, draining or balanced traffic
    task automatic test_random_traffic(input int n_items, input int idle_pct);
        int sent;
        int burst_len;
        int enq_pct;
        int burst_idle;
        sent = 0;
        while (sent < n_items)
        begin
            burst_len = $urandom_range(40, 8);
            case ($urandom_range(2))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            // some bursts run back to back even in idle phases
            burst_idle = ($urandom_range(3) == 0) ? 0 : idle_pct;
            for (int i = 0; i < burst_len && sent < n_items; i++)
            begin
                send_word(random_word(enq_pct));
                idle_for(pick_gap(burst_idle));
                sent++;
            end
        end
    endtask

    initial
    begin
        start <= 1'b0;
        cmd   <= '0;
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_dequeue();
        test_time_extremes();
        test_tie_order();
        test_full_refusal();

        test_random_traffic(400, 0);
        test_random_traffic(400, 77);
        test_random_traffic(400, 38);

        // drain: wait for every pending result word, then idle with start low
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Covered %0d words at three pacing levels: %0d enqueues (%0d refused full), %0d dequeues (%0d refused empty)",
                 enq_count + deq_count, enq_count, full_count, deq_count, empty_count);
        $display("%0d result words checked, %0d errors", checked_count, error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("timeout with %0d result words pending", pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
